>>> rtl/u256ct_pkg.sv
package u256ct_pkg;

	localparam int unsigned DivBits    = 256;
	localparam int unsigned StepBits   = 4;
	localparam int unsigned NumStages  = DivBits / StepBits;
	localparam int unsigned NumLimbs   = 8;

	localparam logic [31:0] CompactSign  = 32'h0080_0000;
	localparam logic [31:0] CompactMant  = 32'h00ff_ffff;
	localparam logic [31:0] Word32Mask   = 32'hffff_ffff;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_SHR      = 4'd4,
		OP_SHL      = 4'd5,
		OP_CMP      = 4'd6,
		OP_BITLEN   = 4'd7,
		OP_LEADZERO = 4'd8,
		OP_DECODE   = 4'd9,
		OP_ENCODE   = 4'd10
	} op_t;

	typedef struct packed {
		op_t                        op;
		logic [255:0]               a;
		logic [255:0]               b;
		logic [31:0]                word;
		logic [8:0]                 shamt;
		logic                       sgn;
		logic [NumLimbs-1:0][63:0]  pp;
		logic [NumLimbs-1:0][5:0]   lz;
		logic [NumLimbs-1:0]        nz;
		logic [8:0]                 bl;
		logic [255:0]               q;
		logic [31:0]                rem;
		logic [255:0]               res;
		logic                       lt;
		logic                       eq;
		logic [8:0]                 cnt;
		logic [31:0]                cmp;
		logic                       neg;
		logic                       ovf;
		logic                       derr;
	} stage_t;

	// Leading zeros of one 32-bit limb, by halving.
	function automatic logic [5:0] lzc32(input logic [31:0] x);
		logic [31:0] v;
		logic [5:0]  n;
		v = x;
		n = '0;
		if (x == '0) begin
			n = 6'd32;
		end else begin
			if (v[31:16] == '0) begin n = n + 6'd16; v = v << 16; end
			if (v[31:24] == '0) begin n = n + 6'd8;  v = v << 8;  end
			if (v[31:28] == '0) begin n = n + 6'd4;  v = v << 4;  end
			if (v[31:30] == '0) begin n = n + 6'd2;  v = v << 2;  end
			if (v[31] == 1'b0)  begin n = n + 6'd1; end
		end
		return n;
	endfunction

	// Restoring division: StepBits quotient bits; the dividend shifts out
	// at the top of q and the quotient shifts in at the bottom.
	function automatic logic [287:0] div_step(input logic [31:0] rem_in,
		input logic [255:0] q_in, input logic [31:0] d);
		logic [31:0]  r;
		logic [255:0] q;
		logic [32:0]  t;
		r = rem_in;
		q = q_in;
		for (int j = 0; j < StepBits; j++) begin
			t = {r, q[255]};
			q = {q[254:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				q[0] = 1'b1;
			end
			r = t[31:0];
		end
		return {r, q};
	endfunction

endpackage

>>> rtl/u256ct_req_if.sv
interface u256ct_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  req_type;
	logic [63:0] a_word0;
	logic [63:0] a_word1;
	logic [63:0] a_word2;
	logic [63:0] a_word3;
	logic [63:0] b_word0;
	logic [63:0] b_word1;
	logic [63:0] b_word2;
	logic [63:0] b_word3;
	logic [31:0] operand_word;
	logic [8:0]  shift_amount;
	logic        sign_in;

	modport source(output valid, req_type, a_word0, a_word1, a_word2, a_word3,
		b_word0, b_word1, b_word2, b_word3, operand_word, shift_amount, sign_in,
		input ready);
	modport sink(input valid, req_type, a_word0, a_word1, a_word2, a_word3,
		b_word0, b_word1, b_word2, b_word3, operand_word, shift_amount, sign_in,
		output ready);
endinterface

>>> rtl/u256ct_rsp_if.sv
interface u256ct_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] r_word0;
	logic [63:0] r_word1;
	logic [63:0] r_word2;
	logic [63:0] r_word3;
	logic        less_than;
	logic        equal_flag;
	logic [8:0]  bit_count;
	logic [31:0] compact_out;
	logic        negative_flag;
	logic        overflow_flag;
	logic        divide_error;

	modport source(output valid, r_word0, r_word1, r_word2, r_word3, less_than,
		equal_flag, bit_count, compact_out, negative_flag, overflow_flag,
		divide_error, input ready);
	modport sink(input valid, r_word0, r_word1, r_word2, r_word3, less_than,
		equal_flag, bit_count, compact_out, negative_flag, overflow_flag,
		divide_error, output ready);
endinterface

>>> rtl/uint256_alu_with_compact_target_core.sv
// 256-bit unsigned ALU with compact-target (nBits) coding.
//
// Channels: req carries one operation per item (req_type selects add, sub,
// mul, div, shr, shl, compare, bit length, leading zeros, compact decode or
// compact encode); rsp returns exactly one result item per request, in order.
// Both use valid/ready; an item moves when valid and ready are high at a
// rising edge of clk.
//
// The divider retires four quotient bits per stage over 64 stages, and all
// other work rides the same stages (partial products and limb leading zeros
// in stage 1; add/sub/mul/shift/compare/bit length/leading zeros/decode in
// stage 2; encode in stage 3). Throughput is one item per cycle unless stalled.
//
// Reset (arst_n low) empties the pipeline at once; no results are pending.
// When the receiver holds rsp.ready low with a result waiting, the whole
// pipeline freezes and req.ready drops; nothing is lost or repeated, and
// bubbles inside the pipeline are not squeezed out during the stall.
module uint256_alu_with_compact_target_core
	import u256ct_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	u256ct_req_if.sink   req,
	u256ct_rsp_if.source rsp
);

	logic   [NumStages:1] vld_s;
	stage_t               dat_s [1:NumStages];
	stage_t               prev  [1:NumStages];
	stage_t               nxt   [1:NumStages];
	stage_t               in_st;
	logic                 advance;

	// Advance everything whenever the last stage is empty or being drained.
	assign advance   = !vld_s[NumStages] || rsp.ready;
	assign req.ready = advance;

	// Build the entering item; every result field starts at zero and q holds the dividend.
	always_comb begin
		in_st       = '0;
		in_st.op    = op_t'(req.req_type);
		in_st.a     = {req.a_word3, req.a_word2, req.a_word1, req.a_word0};
		in_st.b     = {req.b_word3, req.b_word2, req.b_word1, req.b_word0};
		in_st.word  = req.operand_word;
		in_st.shamt = req.shift_amount;
		in_st.sgn   = req.sign_in;
		in_st.q     = in_st.a;
	end

	always_comb begin
		prev[1] = in_st;
		for (int k = 2; k <= NumStages; k++) begin
			prev[k] = dat_s[k-1];
		end
	end

	always_comb begin
		stage_t        p;
		stage_t        n;
		logic [255:0]  ev;
		logic [255:0]  ov;
		logic [7:0]    dsz;
		logic [22:0]   dm;
		logic [8:0]    bl;
		logic [5:0]    esz;
		logic [31:0]   ec;
		logic [255:0]  et;
		for (int k = 1; k <= NumStages; k++) begin
			p   = prev[k];
			n   = p;
			ev  = '0;
			ov  = '0;
			dsz = '0;
			dm  = '0;
			bl  = '0;
			esz = '0;
			ec  = '0;
			et  = '0;
			{n.rem, n.q} = div_step(p.rem, p.q, p.word);

			// Stage 1: scalar products and per-limb leading zeros.
			if (k == 1) begin
				for (int i = 0; i < NumLimbs; i++) begin
					n.pp[i] = 64'(p.a[32*i +: 32]) * 64'(p.word);
					n.lz[i] = lzc32(p.a[32*i +: 32]);
					n.nz[i] = |p.a[32*i +: 32];
				end
			end

			// Stage 2: the single-pass operations.
			if (k == 2) begin
				for (int i = 0; i < NumLimbs; i++) begin
					if (p.nz[i]) begin
						bl = 9'(32 * i + 32) - 9'(p.lz[i]);
					end
				end
				n.bl = bl;
				ev  = {p.pp[6], p.pp[4], p.pp[2], p.pp[0]};
				ov  = {p.pp[7][31:0], p.pp[5], p.pp[3], p.pp[1], 32'h0};
				dsz = p.word[31:24];
				dm  = p.word[22:0];
				case (p.op)
					OP_ADD: begin
						n.res = p.a + p.b;
					end
					OP_SUB: begin
						n.res = p.a - p.b;
					end
					OP_MUL: begin
						n.res = ev + ov;
					end
					OP_SHR: begin
						n.res = p.shamt[8] ? '0 : (p.a >> p.shamt[7:0]);
					end
					OP_SHL: begin
						n.res = p.shamt[8] ? '0 : (p.a << p.shamt[7:0]);
					end
					OP_CMP: begin
						n.lt = (p.a < p.b);
						n.eq = (p.a == p.b);
					end
					OP_BITLEN: begin
						n.cnt = bl;
					end
					OP_LEADZERO: begin
						n.cnt = 9'd256 - bl;
					end
					OP_DECODE: begin
						if (dsz <= 8'd3) begin
							n.res = 256'(dm) >> {2'(8'd3 - dsz), 3'b000};
						end else if (dsz <= 8'd34) begin
							n.res = 256'(dm) << {5'(dsz - 8'd3), 3'b000};
						end else begin
							n.res = '0;
						end
						n.neg = (dm != '0) && p.word[23];
						n.ovf = (dm != '0) && ((dsz > 8'd34) ||
							((dm > 23'h0000ff) && (dsz > 8'd33)) ||
							((dm > 23'h00ffff) && (dsz > 8'd32)));
					end
					default: begin
					end
				endcase
			end

			// Stage 3: compact encode from the bit length found in stage 2.
			if (k == 3) begin
				esz = 6'((p.bl + 9'd7) >> 3);
				et  = p.a >> {5'(esz - 6'd3), 3'b000};
				if (esz <= 6'd3) begin
					ec = p.a[31:0] << {2'(6'd3 - esz), 3'b000};
				end else begin
					ec = et[31:0];
				end
				ec = ec & CompactMant;
				if ((ec & CompactSign) != '0) begin
					ec  = ec >> 8;
					esz = esz + 6'd1;
				end
				ec[31:24] = 8'(esz);
				if (p.sgn && (ec[22:0] != '0)) begin
					ec = ec | CompactSign;
				end
				if (p.op == OP_ENCODE) begin
					n.cmp = ec & Word32Mask;
				end
			end

			// Last stage: the quotient is complete.
			if (k == NumStages) begin
				if (p.op == OP_DIV) begin
					if (p.word == '0) begin
						n.derr = 1'b1;
						n.res  = '0;
					end else begin
						n.res = n.q;
					end
				end
			end
			nxt[k] = n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (advance) begin
			vld_s <= {vld_s[NumStages-1:1], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 1; k <= NumStages; k++) begin
				dat_s[k] <= nxt[k];
			end
		end
	end

	assign rsp.valid         = vld_s[NumStages];
	assign rsp.r_word0       = dat_s[NumStages].res[63:0];
	assign rsp.r_word1       = dat_s[NumStages].res[127:64];
	assign rsp.r_word2       = dat_s[NumStages].res[191:128];
	assign rsp.r_word3       = dat_s[NumStages].res[255:192];
	assign rsp.less_than     = dat_s[NumStages].lt;
	assign rsp.equal_flag    = dat_s[NumStages].eq;
	assign rsp.bit_count     = dat_s[NumStages].cnt;
	assign rsp.compact_out   = dat_s[NumStages].cmp;
	assign rsp.negative_flag = dat_s[NumStages].neg;
	assign rsp.overflow_flag = dat_s[NumStages].ovf;
	assign rsp.divide_error  = dat_s[NumStages].derr;

	// A zero divisor must leave the result words clear.
	a_derr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.divide_error |->
		(rsp.r_word0 == '0) && (rsp.r_word1 == '0) &&
		(rsp.r_word2 == '0) && (rsp.r_word3 == '0))
		else $error("divide error with nonzero result");

	// Compare flags are exclusive.
	a_cmp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.less_than |-> !rsp.equal_flag)
		else $error("less and equal both set");

	// Decode flags never come with encode, count or divide-error results.
	a_dec_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.negative_flag || rsp.overflow_flag) |->
		(rsp.compact_out == '0) && (rsp.bit_count == '0) && !rsp.divide_error)
		else $error("decode flags mixed with other results");

	// A held result blocks the input and keeps its stage.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready ##1 (rsp.valid &&
		$stable(rsp.r_word0) && $stable(rsp.compact_out)))
		else $error("pipeline moved during stall");

endmodule

>>> dv/u256ct_tb_if.sv
package u256ct_tb_pkg;
	import u256ct_pkg::*;

	typedef struct packed {
		logic [255:0] r;
		logic         lt;
		logic         eq;
		logic [8:0]   cnt;
		logic [31:0]  cmp;
		logic         neg;
		logic         ovf;
		logic         derr;
	} alu_result_t;

	typedef struct packed {
		op_t          op;
		logic [255:0] a;
		logic [255:0] b;
		logic [31:0]  word;
		logic [8:0]   shamt;
		logic         sgn;
	} alu_request_t;
endpackage

>>> dv/testbench.sv
module testbench
	import u256ct_pkg::*, u256ct_tb_pkg::*;
;

	localparam int unsigned PipeDepth = 64;
	localparam int unsigned RandomItems = 1150;
	localparam int unsigned StallLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	u256ct_req_if req ();
	u256ct_rsp_if rsp ();

	uint256_alu_with_compact_target_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	always #1 clk = ~clk;

	// Results waiting to come out of the pipeline, oldest first.
	alu_result_t pending_results[$];
	int unsigned error_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// Bit length of a 256-bit value: index of the highest set bit plus one.
	function automatic logic [8:0] bits_used(input logic [255:0] v);
		logic [8:0] n;
		n = '0;
		for (int i = 0; i < 256; i++) begin
			if (v[i]) n = 9'(i + 1);
		end
		return n;
	endfunction

	// Compute the expected result of one request.
	function automatic alu_result_t alu_predict(input alu_request_t q);
		alu_result_t  e;
		logic [287:0] wide;
		logic [7:0]   size;
		logic [22:0]  mant;
		logic [31:0]  c;
		logic [8:0]   n;
		e = '0;
		case (q.op)
			OP_ADD: e.r = q.a + q.b;
			OP_SUB: e.r = q.a - q.b;
			OP_MUL: begin
				wide = q.a * {256'd0, q.word};
				e.r = wide[255:0];
			end
			OP_DIV: begin
				if (q.word == '0) e.derr = 1'b1;
				else e.r = q.a / {224'd0, q.word};
			end
			OP_SHR: e.r = (q.shamt >= 9'd256) ? '0 : q.a >> q.shamt;
			OP_SHL: e.r = (q.shamt >= 9'd256) ? '0 : q.a << q.shamt;
			OP_CMP: begin
				e.lt = q.a < q.b;
				e.eq = q.a == q.b;
			end
			OP_BITLEN: e.cnt = bits_used(q.a);
			OP_LEADZERO: e.cnt = 9'd256 - bits_used(q.a);
			OP_DECODE: begin
				size = q.word[31:24];
				mant = q.word[22:0];
				if (size <= 8'd3) e.r = 256'(mant) >> (8 * (3 - size));
				else if (size >= 8'd35) e.r = '0;
				else e.r = 256'(mant) << (8 * (size - 3));
				e.neg = (mant != '0) && q.word[23];
				e.ovf = (mant != '0) && (size > 8'd34 || (mant > 23'hff && size > 8'd33)
					|| (mant > 23'hffff && size > 8'd32));
			end
			OP_ENCODE: begin
				n = bits_used(q.a);
				size = 8'((n + 9'd7) / 9'd8);
				if (size <= 8'd3) c = q.a[31:0] << (8 * (3 - size));
				else c = 32'(q.a >> (8 * (size - 3)));
				c = c & CompactMant;
				// Keep the sign position clear: push the mantissa down a byte.
				if ((c & CompactSign) != '0) begin
					c = c >> 8;
					size = size + 8'd1;
				end
				c = c | {size, 24'd0};
				if (q.sgn && c[22:0] != '0) c = c | CompactSign;
				e.cmp = c;
			end
			default: e = '0;
		endcase
		return e;
	endfunction

	function automatic logic [255:0] rand256();
		logic [255:0] v;
		for (int i = 0; i < 8; i++) v[32*i +: 32] = $urandom;
		// Thin out the value now and then to reach short operands; sometimes use all ones.
		case ($urandom_range(0, 5))
			0: v = v >> $urandom_range(0, 255);
			1: v = '0;
			2: v = '1;
			default: ;
		endcase
		return v;
	endfunction

	function automatic alu_request_t random_request();
		alu_request_t q;
		q.op = op_t'($urandom_range(0, 15));
		q.a = rand256();
		// Compare with equal or near operands often enough.
		case ($urandom_range(0, 3))
			0: q.b = q.a;
			1: q.b = q.a ^ (256'd1 << $urandom_range(0, 255));
			default: q.b = rand256();
		endcase
		q.word = $urandom;
		if ($urandom_range(0, 7) == 0) q.word = '0;
		if (q.op == OP_DECODE && $urandom_range(0, 1))
			q.word[31:24] = 8'($urandom_range(0, 40));
		q.shamt = 9'($urandom_range(0, 511));
		if ($urandom_range(0, 1)) q.shamt = 9'($urandom_range(0, 255));
		q.sgn = 1'($urandom_range(0, 1));
		return q;
	endfunction

	// Hold the request until the block takes it, then queue its prediction.
	task automatic send_request(input alu_request_t q);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= q.op;
		{req.a_word3, req.a_word2, req.a_word1, req.a_word0} <= q.a;
		{req.b_word3, req.b_word2, req.b_word1, req.b_word0} <= q.b;
		req.operand_word <= q.word;
		req.shift_amount <= q.shamt;
		req.sign_in <= q.sgn;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(alu_predict(q));
	endtask

	task automatic send_directed(input alu_request_t q, input alu_result_t known,
		input bit use_known);
		alu_result_t e;
		e = alu_predict(q);
		if (use_known && e != known) begin
			$error("predictor disagrees with directed row: op=%0d exp=%h got=%h",
				q.op, known, e);
			error_count++;
		end
		send_request(q);
	endtask

	function automatic alu_request_t mk(input op_t op, input logic [255:0] a,
		input logic [255:0] b, input logic [31:0] w, input logic [8:0] s, input logic g);
		alu_request_t q;
		q = '{op: op, a: a, b: b, word: w, shamt: s, sgn: g};
		return q;
	endfunction

	function automatic alu_result_t rk(input logic [255:0] r, input logic [8:0] cnt,
		input logic [31:0] cmp, input logic lt, input logic eq, input logic ovf,
		input logic derr);
		alu_result_t e;
		e = '0;
		e.r = r; e.cnt = cnt; e.cmp = cmp; e.lt = lt; e.eq = eq; e.ovf = ovf;
		e.derr = derr;
		return e;
	endfunction

	typedef struct {
		alu_request_t q;
		alu_result_t  e;
		bit           known;
	} directed_row_t;

	// Receiver: random stall, compare each item against the oldest expectation.
	always @(posedge clk) begin
		alu_result_t e;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$error("result item with nothing expected");
					error_count++;
				end else begin
					e = pending_results.pop_front();
					if (rsp.r_word0 !== e.r[63:0]) begin
						$error("r_word0: exp %h got %h", e.r[63:0], rsp.r_word0);
						error_count++;
					end
					if (rsp.r_word1 !== e.r[127:64]) begin
						$error("r_word1: exp %h got %h", e.r[127:64], rsp.r_word1);
						error_count++;
					end
					if (rsp.r_word2 !== e.r[191:128]) begin
						$error("r_word2: exp %h got %h", e.r[191:128], rsp.r_word2);
						error_count++;
					end
					if (rsp.r_word3 !== e.r[255:192]) begin
						$error("r_word3: exp %h got %h", e.r[255:192], rsp.r_word3);
						error_count++;
					end
					if (rsp.less_than !== e.lt) begin
						$error("less_than: exp %0d got %0d", e.lt, rsp.less_than);
						error_count++;
					end
					if (rsp.equal_flag !== e.eq) begin
						$error("equal_flag: exp %0d got %0d", e.eq, rsp.equal_flag);
						error_count++;
					end
					if (rsp.bit_count !== e.cnt) begin
						$error("bit_count: exp %0d got %0d", e.cnt, rsp.bit_count);
						error_count++;
					end
					if (rsp.compact_out !== e.cmp) begin
						$error("compact_out: exp %h got %h", e.cmp, rsp.compact_out);
						error_count++;
					end
					if (rsp.negative_flag !== e.neg) begin
						$error("negative_flag: exp %0d got %0d", e.neg, rsp.negative_flag);
						error_count++;
					end
					if (rsp.overflow_flag !== e.ovf) begin
						$error("overflow_flag: exp %0d got %0d", e.ovf, rsp.overflow_flag);
						error_count++;
					end
					if (rsp.divide_error !== e.derr) begin
						$error("divide_error: exp %0d got %0d", e.derr, rsp.divide_error);
						error_count++;
					end
				end
			end
			rsp.ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		directed_row_t rows[$];
		logic [255:0] ones;
		int unsigned phase;
		ones = '1;
		req.valid = 1'b0;
		req.req_type = OP_ADD;
		{req.a_word3, req.a_word2, req.a_word1, req.a_word0} = '0;
		{req.b_word3, req.b_word2, req.b_word1, req.b_word0} = '0;
		req.operand_word = '0;
		req.shift_amount = '0;
		req.sign_in = 1'b0;
		rsp.ready = 1'b1;

		// Directed rows: expected values typed only where obvious.
		rows.push_back('{mk(OP_ADD, ones, 256'd1, 0, 0, 0), rk(0, 0, 0, 0, 0, 0, 0), 1});
		rows.push_back('{mk(OP_SUB, 0, 256'd1, 0, 0, 0), rk(ones, 0, 0, 0, 0, 0, 0), 1});
		rows.push_back('{mk(OP_MUL, ones, 0, 32'hffffffff, 0, 0), '0, 0});
		rows.push_back('{mk(OP_DIV, ones, 0, 0, 0, 0), rk(0, 0, 0, 0, 0, 0, 1), 1});
		rows.push_back('{mk(OP_DIV, ones, 0, 32'hffffffff, 0, 0), '0, 0});
		rows.push_back('{mk(OP_DIV, ones, 0, 1, 0, 0), rk(ones, 0, 0, 0, 0, 0, 0), 1});
		rows.push_back('{mk(OP_SHR, ones, 0, 0, 9'd256, 0), rk(0, 0, 0, 0, 0, 0, 0), 1});
		rows.push_back('{mk(OP_SHL, ones, 0, 0, 9'd511, 0), rk(0, 0, 0, 0, 0, 0, 0), 1});
		rows.push_back('{mk(OP_SHR, ones, 0, 0, 9'd255, 0), rk(1, 0, 0, 0, 0, 0, 0), 1});
		rows.push_back('{mk(OP_SHL, ones, 0, 0, 9'd0, 0), rk(ones, 0, 0, 0, 0, 0, 0), 1});
		rows.push_back('{mk(OP_CMP, ones, ones, 0, 0, 0), rk(0, 0, 0, 0, 1, 0, 0), 1});
		rows.push_back('{mk(OP_CMP, 0, ones, 0, 0, 0), rk(0, 0, 0, 1, 0, 0, 0), 1});
		rows.push_back('{mk(OP_BITLEN, ones, 0, 0, 0, 0), rk(0, 9'd256, 0, 0, 0, 0, 0), 1});
		rows.push_back('{mk(OP_LEADZERO, 0, 0, 0, 0, 0), rk(0, 9'd256, 0, 0, 0, 0, 0), 1});
		rows.push_back('{mk(OP_DECODE, 0, 0, 32'h1d00ffff, 0, 0), '0, 0});
		rows.push_back('{mk(OP_DECODE, 0, 0, 32'h01fedcba, 0, 0), '0, 0});
		rows.push_back('{mk(OP_DECODE, 0, 0, 32'hff7fffff, 0, 0), '0, 0});
		rows.push_back('{mk(OP_DECODE, 0, 0, 32'h22000100, 0, 0), '0, 0});
		rows.push_back('{mk(OP_DECODE, 0, 0, 32'h04800000, 0, 0), '0, 0});
		rows.push_back('{mk(OP_ENCODE, 0, 0, 0, 0, 1), rk(0, 0, 0, 0, 0, 0, 0), 1});
		rows.push_back('{mk(OP_ENCODE, 256'h80, 0, 0, 0, 1), rk(0, 0, 32'h02808000, 0, 0, 0, 0), 1});
		rows.push_back('{mk(OP_ENCODE, ones, 0, 0, 0, 1), '0, 0});
		rows.push_back('{mk(OP_ENCODE, 256'h12345, 0, 0, 0, 1), '0, 0});
		rows.push_back('{mk(op_t'(4'd15), ones, ones, '1, '1, 1), '0, 1});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_directed(rows[i].q, rows[i].e, rows[i].known);

		// Random part in four idling phases.
		for (int i = 0; i < RandomItems; i++) begin
			phase = i / (RandomItems / 4);
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 70; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 70; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			send_request(random_request());
		end
		req.valid <= 1'b0;
		recv_stall_pct = 0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (PipeDepth + 8) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

>>> filelist.f
rtl/u256ct_pkg.sv
rtl/u256ct_req_if.sv
rtl/u256ct_rsp_if.sv
rtl/uint256_alu_with_compact_target_core.sv
dv/u256ct_tb_if.sv
dv/testbench.sv
